// ----- hdl/fts_pkg.sv -----
// Shared types and constants of the frame timing statistics block.
// No dependencies; every other file imports this package.
package fts_pkg;

	localparam int FT_W     = 36;
	localparam int FTP_W    = 35;
	localparam int FRM_W    = 8;
	localparam int TOT_W    = 32;
	localparam int LOST_W   = 33;
	localparam int RATE_W   = 32;
	localparam int MEAN_W   = 43;
	localparam int DEV_W    = 24;
	localparam int ALPHA_W  = 16;
	localparam int WARM_W   = 16;
	localparam int CIDX_W   = 1;
	localparam int CDATA_W  = 16;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [29:0] NS_PER_S  = 30'd1000000000;
	localparam logic [22:0] DEV_SCALE = 23'd6553600;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 16'd6554;
	localparam logic [WARM_W-1:0]  WARMUP_RESET = 16'd240;

	typedef enum logic [0:0] {
		CMD_RECORD = 1'b0,
		CMD_CLEAR  = 1'b1
	} command_t;

	typedef enum logic [0:0] {
		REG_SMOOTHING = 1'b0,
		REG_WARMUP    = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_COUNT,
		OP_TIMED
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [FTP_W-1:0] ft;
		logic [FRM_W-1:0] run;
		logic [FRM_W-1:0] req;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [WARM_W-1:0]  warmup;
	} cfg_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_LOAD,
		B_MEAN,
		B_AD,
		B_STEP,
		B_VMUL,
		B_VSUM,
		B_VSCALE,
		B_WARM,
		B_RLO,
		B_RHI,
		B_RCHK,
		B_SQ0,
		B_SQRT,
		B_DMUL,
		B_DCHK,
		B_DIV,
		B_DONE
	} bstate_t;

endpackage

// ----- hdl/fts_if.sv -----
// Stream interfaces of the frame timing statistics block: input words and result words.
// Depends on fts_pkg for field widths.
interface fts_in_if;
	import fts_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic signed [FT_W-1:0]  frame_time_ns;
	logic [FRM_W-1:0]        frames_run;
	logic [FRM_W-1:0]        frames_requested;

	modport source (output valid, command, frame_time_ns, frames_run, frames_requested,
		input ready);
	modport sink (input valid, command, frame_time_ns, frames_run, frames_requested,
		output ready);
endinterface

interface fts_out_if;
	import fts_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [TOT_W-1:0]         run_total;
	logic [TOT_W-1:0]         requested_total;
	logic signed [LOST_W-1:0] lost_total;
	logic [RATE_W-1:0]        rate_fps_q16;
	logic [MEAN_W-1:0]        mean_time_q8;
	logic [DEV_W-1:0]         deviation_pct_q8;
	logic                     timing_updated;

	modport source (output valid, run_total, requested_total, lost_total, rate_fps_q16,
		mean_time_q8, deviation_pct_q8, timing_updated, input ready);
	modport sink (input valid, run_total, requested_total, lost_total, rate_fps_q16,
		mean_time_q8, deviation_pct_q8, timing_updated, output ready);
endinterface

// ----- hdl/fts_front.sv -----
// Front end: takes input words and classifies them into queue entries.
// Depends on fts_pkg and fts_in_if.
module fts_front (
	fts_in_if.sink          items,
	input  fts_pkg::qstat_t qstat,
	output logic            push,
	output fts_pkg::item_t  entry
);
	import fts_pkg::*;

	logic timed;

	assign items.ready = !qstat.full;
	assign push        = items.valid && !qstat.full;

	// positive frame time only
	assign timed = !items.frame_time_ns[FT_W-1] && (items.frame_time_ns != '0);

	always_comb begin
		if (items.command == CMD_CLEAR) begin
			entry.op = OP_CLEAR;
		end else if (timed) begin
			entry.op = OP_TIMED;
		end else begin
			entry.op = OP_COUNT;
		end
		entry.ft  = items.frame_time_ns[FTP_W-1:0];
		entry.run = items.frames_run;
		entry.req = items.frames_requested;
	end
endmodule

// ----- hdl/fts_queue.sv -----
// Short queue of classified words between front end and back end.
// Depends on fts_pkg.
module fts_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fts_pkg::item_t  entry,
	input  logic            pop,
	output fts_pkg::item_t  head,
	output fts_pkg::qstat_t qstat
);
	import fts_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push, do_pop;

	assign qstat.full  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (fill_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end
endmodule

// ----- hdl/fts_back.sv -----
// Back end: sequencer that updates counts, moving mean and variance, rate and deviation.
// Depends on fts_pkg and fts_out_if; bit-serial multiply, divide and square root.
module fts_back #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fts_pkg::cfg_t   cfg,
	input  fts_pkg::item_t  head,
	input  fts_pkg::qstat_t qstat,
	output logic            pop,
	fts_out_if.source       results
);
	import fts_pkg::*;

	localparam int CW = COUNT_WIDTH;

	function automatic logic [CW-1:0] sat_cnt(input logic [CW-1:0] c, input logic [FRM_W-1:0] f);
		logic [CW:0] s;
		s = {1'b0, c} + {{(CW+1-FRM_W){1'b0}}, f};
		sat_cnt = s[CW] ? '1 : s[CW-1:0];
	endfunction

	function automatic logic [TOT_W-1:0] clamp32(input logic [CW-1:0] c);
		logic [CW+TOT_W:0] e;
		e = {{(TOT_W+1){1'b0}}, c};
		clamp32 = (e > (CW+TOT_W+1)'({TOT_W{1'b1}})) ? '1 : e[TOT_W-1:0];
	endfunction

	bstate_t state_q, state_d;
	logic [5:0]  cnt_q;
	item_t       it_q;
	logic        seeded_q;
	logic [43:0] mean_q;
	logic [63:0] var_q;
	logic [CW-1:0] warm_q, counted_q, run_q, req_q;
	logic [63:0] elapsed_q;
	logic [31:0] rate_q;
	logic [43:0] hmean_q;
	logic [23:0] hdev_q;
	logic        upd_q;
	logic        up_q;
	logic [43:0] d_q;
	logic [59:0] ad_q;
	logic [109:0] prod_q;
	logic [63:0] rem_q, div_q, sqv_q, sqres_q, sqbit_q;
	logic [31:0] dl_q, quo_q;
	logic        div_dev_q;
	logic [54:0] num_q;
	logic        out_valid_q;

	logic        slot_free, load_out;
	logic [43:0] sample, diff_c, step_c;
	logic        up_c;
	logic [60:0] rnd_c;
	logic [103:0] vstep_c;
	logic [63:0] term_c, vsum_c;
	logic [64:0] vsum65_c, el65_c;
	logic [16:0] om_c;
	logic [80:0] vp_c;
	logic [63:0] c64, rlo_c, rhi_c;
	logic [109:0] n_c, dd_c;
	logic [64:0] r2_c;
	logic        dge_c;
	logic [64:0] sqt_c;
	logic        sqge_c;
	logic        warming;

	assign slot_free = !out_valid_q || results.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:   if (!qstat.empty) state_d = B_LOAD;
			B_LOAD: begin
				if (it_q.op == OP_TIMED) begin
					state_d = seeded_q ? B_MEAN : B_WARM;
				end else begin
					state_d = B_DONE;
				end
			end
			B_MEAN:   state_d = B_AD;
			B_AD:     state_d = B_STEP;
			B_STEP:   state_d = B_VMUL;
			B_VMUL:   if (cnt_q == '0) state_d = B_VSUM;
			B_VSUM:   state_d = B_VSCALE;
			B_VSCALE: state_d = B_WARM;
			B_WARM:   state_d = B_RLO;
			B_RLO:    state_d = (counted_q != '0 && elapsed_q != '0) ? B_RHI : B_SQ0;
			B_RHI:    state_d = B_RCHK;
			B_RCHK:   state_d = (n_c >= dd_c) ? B_SQ0 : B_DIV;
			B_SQ0:    state_d = B_SQRT;
			B_SQRT:   if (cnt_q == '0) state_d = B_DMUL;
			B_DMUL:   state_d = B_DCHK;
			B_DCHK: begin
				if (mean_q == '0 || {13'b0, num_q} >= {mean_q, 24'b0}) begin
					state_d = B_DONE;
				end else begin
					state_d = B_DIV;
				end
			end
			B_DIV:    if (cnt_q == '0) state_d = div_dev_q ? B_DONE : B_SQ0;
			B_DONE:   if (slot_free) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE:  pop = !qstat.empty;
			B_DONE:  load_out = slot_free;
			default: begin
				pop      = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// datapath arithmetic
	always_comb begin
		sample   = {1'b0, it_q.ft, 8'b0};
		up_c     = sample >= mean_q;
		diff_c   = up_c ? sample - mean_q : mean_q - sample;
		rnd_c    = {1'b0, ad_q} + 61'd32768;
		step_c   = rnd_c[59:16];
		vstep_c  = {prod_q[102:0], 1'b0} + {44'b0, ad_q & {60{d_q[cnt_q]}}};
		term_c   = (prod_q[103:96] != '0) ? '1 : prod_q[95:32];
		vsum65_c = {1'b0, var_q} + {1'b0, term_c};
		vsum_c   = vsum65_c[64] ? '1 : vsum65_c[63:0];
		om_c     = 17'h10000 - {1'b0, cfg.alpha};
		vp_c     = {17'b0, var_q} * {64'b0, om_c};
		el65_c   = {1'b0, elapsed_q} + {30'b0, it_q.ft};
		warming  = {{WARM_W{1'b0}}, warm_q} < {{CW{1'b0}}, cfg.warmup};
		c64      = 64'(counted_q);
		rlo_c    = {32'b0, c64[31:0]} * {34'b0, NS_PER_S};
		rhi_c    = {32'b0, c64[63:32]} * {34'b0, NS_PER_S};
		n_c      = {prod_q[93:0], 16'b0};
		dd_c     = {14'b0, elapsed_q, 32'b0};
		r2_c     = {rem_q, dl_q[31]};
		dge_c    = r2_c >= {1'b0, div_q};
		sqt_c    = {1'b0, sqres_q} + {1'b0, sqbit_q};
		sqge_c   = {1'b0, sqv_q} >= sqt_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			seeded_q    <= 1'b0;
			mean_q      <= '0;
			var_q       <= '0;
			warm_q      <= '0;
			counted_q   <= '0;
			elapsed_q   <= '0;
			run_q       <= '0;
			req_q       <= '0;
			rate_q      <= '0;
			hmean_q     <= '0;
			hdev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_LOAD: begin
					if (it_q.op == OP_CLEAR) begin
						seeded_q  <= 1'b0;
						mean_q    <= '0;
						var_q     <= '0;
						warm_q    <= '0;
						counted_q <= '0;
						elapsed_q <= '0;
						run_q     <= '0;
						req_q     <= '0;
					end else begin
						run_q <= sat_cnt(run_q, it_q.run);
						req_q <= sat_cnt(req_q, it_q.req);
						if (it_q.op == OP_TIMED && !seeded_q) begin
							mean_q   <= sample;
							var_q    <= '0;
							seeded_q <= 1'b1;
						end
					end
				end
				B_STEP:   mean_q <= up_q ? mean_q + step_c : mean_q - step_c;
				B_VSUM:   var_q <= vsum_c;
				B_VSCALE: var_q <= vp_c[79:16];
				B_WARM: begin
					if (warming) begin
						warm_q <= sat_cnt(warm_q, it_q.run);
					end else begin
						elapsed_q <= el65_c[64] ? '1 : el65_c[63:0];
						counted_q <= sat_cnt(counted_q, it_q.run);
					end
				end
				B_RCHK:   if (n_c >= dd_c) rate_q <= '1;
				B_DMUL:   hmean_q <= mean_q;
				B_DCHK: begin
					if (mean_q == '0) begin
						hdev_q <= '0;
					end else if ({13'b0, num_q} >= {mean_q, 24'b0}) begin
						hdev_q <= '1;
					end
				end
				B_DIV: begin
					if (cnt_q == '0) begin
						if (div_dev_q) begin
							hdev_q <= {quo_q[22:0], dge_c};
						end else begin
							rate_q <= {quo_q[30:0], dge_c};
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			it_q <= head;
		end
		case (state_q)
			B_LOAD: upd_q <= (it_q.op == OP_TIMED);
			B_MEAN: begin
				up_q <= up_c;
				d_q  <= diff_c;
			end
			B_AD:   ad_q <= 60'({44'b0, cfg.alpha} * {16'b0, d_q});
			B_STEP: begin
				prod_q <= '0;
				cnt_q  <= 6'd43;
			end
			B_VMUL: begin
				prod_q <= {6'b0, vstep_c};
				cnt_q  <= cnt_q - 1'b1;
			end
			B_RLO:  prod_q <= {46'b0, rlo_c};
			B_RHI:  prod_q <= prod_q + {14'b0, rhi_c, 32'b0};
			B_RCHK: begin
				rem_q     <= n_c[95:32];
				dl_q      <= n_c[31:0];
				div_q     <= elapsed_q;
				div_dev_q <= 1'b0;
				quo_q     <= '0;
				cnt_q     <= 6'd31;
			end
			B_SQ0: begin
				sqv_q   <= var_q;
				sqres_q <= '0;
				sqbit_q <= 64'h4000_0000_0000_0000;
				cnt_q   <= 6'd31;
			end
			B_SQRT: begin
				if (sqge_c) begin
					sqv_q   <= sqv_q - sqt_c[63:0];
					sqres_q <= (sqres_q >> 1) + sqbit_q;
				end else begin
					sqres_q <= sqres_q >> 1;
				end
				sqbit_q <= sqbit_q >> 2;
				cnt_q   <= cnt_q - 1'b1;
			end
			B_DMUL: num_q <= {23'b0, sqres_q[31:0]} * {32'b0, DEV_SCALE};
			B_DCHK: begin
				rem_q     <= {33'b0, num_q[54:24]};
				dl_q      <= {num_q[23:0], 8'b0};
				div_q     <= {20'b0, mean_q};
				div_dev_q <= 1'b1;
				quo_q     <= '0;
				cnt_q     <= 6'd23;
			end
			B_DIV: begin
				rem_q <= dge_c ? 64'(r2_c - {1'b0, div_q}) : r2_c[63:0];
				dl_q  <= {dl_q[30:0], 1'b0};
				quo_q <= {quo_q[30:0], dge_c};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	logic [TOT_W-1:0] run_o_q, req_o_q;
	logic [RATE_W-1:0] rate_o_q;
	logic [MEAN_W-1:0] mean_o_q;
	logic [DEV_W-1:0] dev_o_q;
	logic upd_o_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			run_o_q  <= clamp32(run_q);
			req_o_q  <= clamp32(req_q);
			rate_o_q <= rate_q;
			mean_o_q <= hmean_q[MEAN_W-1:0];
			dev_o_q  <= hdev_q;
			upd_o_q  <= upd_q;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.run_total        = run_o_q;
	assign results.requested_total  = req_o_q;
	assign results.lost_total       = $signed({1'b0, req_o_q} - {1'b0, run_o_q});
	assign results.rate_fps_q16     = rate_o_q;
	assign results.mean_time_q8     = mean_o_q;
	assign results.deviation_pct_q8 = dev_o_q;
	assign results.timing_updated   = upd_o_q;
endmodule

// ----- hdl/frame_timing_statistics_core.sv -----
// Top level of the frame timing statistics block: configuration registers and the
// front end, queue and back end. Depends on fts_pkg, fts_if and the fts_* modules.
//
// Each input word either clears the statistics or records one frame pass: its frame
// counts go into saturating totals, and a positive frame time also moves an
// exponentially weighted mean and variance of the frame time, feeds warmup or the
// long-run rate totals, and refreshes the held rate, mean and deviation. Every word
// yields exactly one result word. A timed pass runs the back end sequencer through
// a 44-step bit-serial variance multiply, a 32-step rate division, a 32-step square
// root and a 24-step deviation division, all one bit a cycle, where each is needed.
// A two-entry queue holds words the front end has accepted, and the result register
// frees the back end as soon as a result is taken. Configuration (index 0 smoothing
// alpha Q0.16, index 1 warmup frames) is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle; the block does not enforce it.
module frame_timing_statistics_core #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [fts_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [fts_pkg::CDATA_W-1:0] cfg_data,
	fts_in_if.sink                      items,
	fts_out_if.source                   results
);
	import fts_pkg::*;

	cfg_t   cfg_q;
	qstat_t qstat;
	item_t  entry, head;
	logic   push, pop;

	// hold configuration; both registers take the low 16 data bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha  <= ALPHA_RESET;
			cfg_q.warmup <= WARMUP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SMOOTHING: cfg_q.alpha  <= cfg_data;
				REG_WARMUP:    cfg_q.warmup <= cfg_data;
				default:       cfg_q        <= cfg_q;
			endcase
		end
	end

	// classify words and push them into the queue
	fts_front u_front (
		.items (items),
		.qstat (qstat),
		.push  (push),
		.entry (entry)
	);

	fts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (entry),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// carry out the statistics update, one word at a time
	fts_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.results (results)
	);
endmodule

// ----- hdl/fts_checker.sv -----
// Port-level checks of the frame timing statistics block, bound to its top level.
// Depends on fts_pkg for widths.
module fts_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [fts_pkg::TOT_W-1:0]         run_total,
	input logic [fts_pkg::TOT_W-1:0]         requested_total,
	input logic signed [fts_pkg::LOST_W-1:0] lost_total,
	input logic [fts_pkg::MEAN_W-1:0]        mean_time_q8,
	input logic [fts_pkg::DEV_W-1:0]         deviation_pct_q8,
	input logic                              timing_updated
);
	import fts_pkg::*;

	a_lost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lost_total == $signed({1'b0, requested_total} - {1'b0, run_total}))
		else $error("lost total does not match totals");

	a_mean_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timing_updated |-> mean_time_q8 != '0)
		else $error("timing update left a zero mean");

	a_dev_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mean_time_q8 == '0 |-> deviation_pct_q8 == '0)
		else $error("deviation without a mean");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(run_total) && $stable(mean_time_q8))
		else $error("stalled result changed");
endmodule

bind frame_timing_statistics_core fts_checker u_fts_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (results.valid),
	.out_ready        (results.ready),
	.run_total        (results.run_total),
	.requested_total  (results.requested_total),
	.lost_total       (results.lost_total),
	.mean_time_q8     (results.mean_time_q8),
	.deviation_pct_q8 (results.deviation_pct_q8),
	.timing_updated   (results.timing_updated)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of frame_timing_statistics_core: random and directed frame passes.
// Depends on fts_pkg and the fts_in_if / fts_out_if interfaces; predicts every result word.
module tb;
	import fts_pkg::*;

	typedef struct {
		command_t               command;
		logic signed [FT_W-1:0] frame_time_ns;
		logic [FRM_W-1:0]       frames_run;
		logic [FRM_W-1:0]       frames_requested;
	} pass_word_t;

	typedef struct {
		logic [TOT_W-1:0]         run_total;
		logic [TOT_W-1:0]         requested_total;
		logic signed [LOST_W-1:0] lost_total;
		logic [RATE_W-1:0]        rate_fps_q16;
		logic [MEAN_W-1:0]        mean_time_q8;
		logic [DEV_W-1:0]         deviation_pct_q8;
		logic                     timing_updated;
	} stats_word_t;

	localparam logic [63:0] COUNT_SAT    = 64'hFFFF_FFFF;
	localparam logic [63:0] NS_S_Q16     = 64'd65536000000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CIDX_W-1:0]  cfg_index;
	logic [CDATA_W-1:0] cfg_data;

	fts_in_if  items ();
	fts_out_if results ();

	frame_timing_statistics_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (items.sink),
		.results   (results.source)
	);

	// Words waiting to be driven, and result words the block still owes us.
	pass_word_t  pending_passes[$];
	stats_word_t owed_stats[$];
	int          mismatch_count = 0;
	bit          sender_hold = 0;
	bit          calm = 0;
	bit          pass_taken = 0;

	// Shadow copy of the configuration and statistics state.
	logic [15:0] alpha_q16;
	logic [15:0] warmup_limit;
	logic        seeded;
	logic [63:0] mean_q8, variance, warm_count, elapsed_ns, counted_frames;
	logic [63:0] run_count, req_count, held_rate, held_mean, held_dev;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [63:0] add_sat(input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] cap);
		logic [64:0] s;
		s = {1'b0, x} + {1'b0, y};
		return (s > {1'b0, cap}) ? cap : s[63:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Fold one pass word into the shadow statistics and form its result word.
	task automatic fold_pass(input pass_word_t w, output stats_word_t r);
		logic [63:0]  ft, sample, a, d, step, term, total, dev, run_out, req_out;
		logic [127:0] p;
		logic         up;
		r.timing_updated = 1'b0;
		if (w.command == CMD_CLEAR) begin
			seeded = 0;
			mean_q8 = 0;
			variance = 0;
			warm_count = 0;
			elapsed_ns = 0;
			counted_frames = 0;
			run_count = 0;
			req_count = 0;
		end else begin
			run_count = add_sat(run_count, 64'(w.frames_run), COUNT_SAT);
			req_count = add_sat(req_count, 64'(w.frames_requested), COUNT_SAT);
			if (w.frame_time_ns > 0) begin
				ft = {28'd0, w.frame_time_ns};
				sample = ft << 8;
				a = {48'd0, alpha_q16};
				if (!seeded) begin
					// first sample seeds the mean, variance starts at zero
					mean_q8 = sample;
					variance = 0;
					seeded = 1;
				end else begin
					up = sample >= mean_q8;
					d = up ? sample - mean_q8 : mean_q8 - sample;
					step = (a * d + 64'd32768) >> 16;
					mean_q8 = up ? mean_q8 + step : mean_q8 - step;
					p = 128'(a * d) * 128'(d);
					term = (p[127:96] != 0) ? '1 : p[95:32];
					total = add_sat(variance, term, '1);
					p = 128'(total) * 128'(64'd65536 - a);
					variance = (p[127:80] != 0) ? '1 : p[79:16];
				end
				// warmup frames first, long-run totals afterwards
				if (warm_count < 64'(warmup_limit)) begin
					warm_count = add_sat(warm_count, 64'(w.frames_run), COUNT_SAT);
				end else begin
					elapsed_ns = add_sat(elapsed_ns, ft, '1);
					counted_frames = add_sat(counted_frames, 64'(w.frames_run), COUNT_SAT);
				end
				if (counted_frames > 0 && elapsed_ns > 0) begin
					p = 128'(counted_frames) * 128'(NS_S_Q16) / 128'(elapsed_ns);
					held_rate = (p[127:32] != 0) ? 64'hFFFF_FFFF : 64'(p[31:0]);
				end
				held_mean = mean_q8;
				if (mean_q8 > 0) begin
					dev = floor_sqrt(variance) * 64'd6553600 / mean_q8;
					held_dev = (dev > 64'hFF_FFFF) ? 64'hFF_FFFF : dev;
				end else begin
					held_dev = 0;
				end
				r.timing_updated = 1'b1;
			end
		end
		run_out = run_count;
		req_out = req_count;
		r.run_total = run_out[31:0];
		r.requested_total = req_out[31:0];
		r.lost_total = {1'b0, req_out[31:0]} - {1'b0, run_out[31:0]};
		r.rate_fps_q16 = held_rate[31:0];
		r.mean_time_q8 = held_mean[42:0];
		r.deviation_pct_q8 = held_dev[23:0];
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	// Input side: predict every accepted word at the edge that takes it.
	always @(posedge clk) begin
		stats_word_t r;
		pass_word_t  w;
		pass_taken <= items.valid && items.ready;
		if (arst_n && items.valid && items.ready) begin
			w.command = command_t'(items.command);
			w.frame_time_ns = items.frame_time_ns;
			w.frames_run = items.frames_run;
			w.frames_requested = items.frames_requested;
			fold_pass(w, r);
			owed_stats.push_back(r);
		end
	end

	// Driver: hold the word until taken, then advance or idle.
	always @(negedge clk) begin
		pass_word_t w;
		if (!arst_n) begin
			items.valid <= 1'b0;
		end else if (!items.valid || pass_taken) begin
			if (pending_passes.size() != 0 && !sender_hold
					&& (calm || $urandom_range(99) >= 21)) begin
				w = pending_passes.pop_front();
				items.valid <= 1'b1;
				items.command <= w.command;
				items.frame_time_ns <= w.frame_time_ns;
				items.frames_run <= w.frames_run;
				items.frames_requested <= w.frames_requested;
			end else begin
				items.valid <= 1'b0;
			end
		end
	end

	// Receiver stalls at random.
	always @(negedge clk)
		results.ready <= calm || ($urandom_range(99) >= 21);

	// Monitor: compare each taken result word with the oldest prediction.
	always @(posedge clk) begin
		stats_word_t want;
		if (arst_n && results.valid && results.ready) begin
			if (owed_stats.size() == 0) begin
				$display("unexpected result word at %0t", $realtime);
				mismatch_count++;
			end else begin
				want = owed_stats.pop_front();
				if (results.run_total !== want.run_total)
					report_mismatch("run_total", results.run_total, want.run_total);
				if (results.requested_total !== want.requested_total)
					report_mismatch("requested_total", results.requested_total,
						want.requested_total);
				if (results.lost_total !== want.lost_total)
					report_mismatch("lost_total", 64'(results.lost_total),
						64'(want.lost_total));
				if (results.rate_fps_q16 !== want.rate_fps_q16)
					report_mismatch("rate_fps_q16", results.rate_fps_q16, want.rate_fps_q16);
				if (results.mean_time_q8 !== want.mean_time_q8)
					report_mismatch("mean_time_q8", results.mean_time_q8, want.mean_time_q8);
				if (results.deviation_pct_q8 !== want.deviation_pct_q8)
					report_mismatch("deviation_pct_q8", results.deviation_pct_q8,
						want.deviation_pct_q8);
				if (results.timing_updated !== want.timing_updated)
					report_mismatch("timing_updated", results.timing_updated,
						want.timing_updated);
			end
		end
	end

	task automatic queue_pass(input command_t c, input logic signed [FT_W-1:0] ft,
			input logic [7:0] run, input logic [7:0] req);
		pass_word_t w;
		w.command = c;
		w.frame_time_ns = ft;
		w.frames_run = run;
		w.frames_requested = req;
		pending_passes.push_back(w);
	endtask

	// Random pass: frame times near a steady pace for about half the passes, with tiny, huge, zero and negative noise.
	task automatic queue_random_pass();
		int                     pick;
		logic signed [FT_W-1:0] ft;
		logic [7:0]             run, req;
		pick = $urandom_range(99);
		run = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
		req = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
		if (pick < 10)
			ft = {1'b1, 35'({$urandom, $urandom})};
		else if (pick < 14)
			ft = 36'({$urandom, $urandom});
		else if (pick < 17)
			ft = 0;
		else if (pick < 65)
			ft = 36'(16000000 + $urandom_range(0, 4000000));
		else if (pick < 85)
			ft = 36'($urandom_range(1, 1000));
		else
			ft = {1'b0, 35'({$urandom, $urandom})};
		if ($urandom_range(99) < 5)
			queue_pass(CMD_CLEAR, 36'({$urandom, $urandom}), 8'($urandom), 8'($urandom));
		else
			queue_pass(CMD_RECORD, ft, run, req);
	endtask

	// Wait until every queued word is sent and every owed result word has arrived, then settle.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_passes.size() != 0 || items.valid || owed_stats.size() != 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		if (idx == REG_SMOOTHING)
			alpha_q16 = value;
		else
			warmup_limit = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_phase(input logic [15:0] alpha, input logic [15:0] warm,
			input int count);
		write_reg(REG_SMOOTHING, alpha);
		write_reg(REG_WARMUP, warm);
		repeat (count) queue_random_pass();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SMOOTHING;
		cfg_data = 0;
		items.valid = 1'b0;
		items.command = CMD_RECORD;
		items.frame_time_ns = 0;
		items.frames_run = 0;
		items.frames_requested = 0;
		results.ready = 1'b0;
		alpha_q16 = ALPHA_RESET;
		warmup_limit = WARMUP_RESET;
		seeded = 0;
		{mean_q8, variance, warm_count, elapsed_ns, counted_frames} = '0;
		{run_count, req_count, held_rate, held_mean, held_dev} = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: untimed passes before any seed, then seeding and extremes.
		queue_pass(CMD_RECORD, 0, 8'd0, 8'd0);
		queue_pass(CMD_RECORD, -36'sd1, 8'd255, 8'd0);
		queue_pass(CMD_RECORD, {1'b1, 35'd0}, 8'd0, 8'd255);
		queue_pass(CMD_RECORD, 36'sd1, 8'd1, 8'd1);
		queue_pass(CMD_RECORD, {1'b0, {35{1'b1}}}, 8'd255, 8'd255);
		queue_pass(CMD_RECORD, 36'sd1, 8'd240, 8'd3);
		queue_pass(CMD_RECORD, 36'sd16666667, 8'd1, 8'd2);
		queue_pass(CMD_RECORD, 0, 8'd7, 8'd9);
		queue_pass(CMD_CLEAR, {1'b0, {35{1'b1}}}, 8'd255, 8'd255);
		queue_pass(CMD_RECORD, 36'sd33333333, 8'd2, 8'd1);
		queue_pass(CMD_RECORD, 36'sd16666667, 8'd1, 8'd1);
		drain();
		write_reg(REG_WARMUP, 16'd0);
		queue_pass(CMD_RECORD, 36'sd16666667, 8'd1, 8'd1);
		queue_pass(CMD_RECORD, 36'sd16000000, 8'd255, 8'd1);
		queue_pass(CMD_RECORD, 36'sd1, 8'd0, 8'd0);
		queue_pass(CMD_CLEAR, 0, 8'd0, 8'd0);
		queue_pass(CMD_RECORD, 36'sd1, 8'd1, 8'd0);
		drain();

		// Random phases across the register extremes; one runs with no idling.
		random_phase(16'd1, 16'd65535, 170);
		random_phase(16'd65535, 16'd0, 170);
		calm = 1;
		random_phase(ALPHA_RESET, WARMUP_RESET, 170);
		calm = 0;
		random_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 20)), 170);
		random_phase(16'($urandom_range(1, 65535)), 16'($urandom), 100);
		// Hold the sender once with words queued, then release it.
		sender_hold = 1;
		repeat (100) queue_random_pass();
		repeat (50) @(negedge clk);
		sender_hold = 0;
		drain();
		random_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 3)), 170);

		drain();
		repeat (200) @(negedge clk);
		if (mismatch_count == 0 && owed_stats.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("simulation failed");
		$finish;
	end

endmodule
